### src/hrhp_pkg.sv
// Shared types, codes and character helpers for the HTTP request head parser.
// Used by the step logic and the top level; no dependencies.
`timescale 1ns / 1ps

package hrhp_pkg;

  // Default header line limit
  localparam int MAX_HEADERS_DEF = 32;

  // Field codes
  localparam logic [3:0] FC_DELIM   = 4'd0;
  localparam logic [3:0] FC_METHOD  = 4'd1;
  localparam logic [3:0] FC_SCHEME  = 4'd2;
  localparam logic [3:0] FC_HOST    = 4'd3;
  localparam logic [3:0] FC_PORT    = 4'd4;
  localparam logic [3:0] FC_PATH    = 4'd5;
  localparam logic [3:0] FC_QUERY   = 4'd6;
  localparam logic [3:0] FC_VERSION = 4'd7;
  localparam logic [3:0] FC_HNAME   = 4'd8;
  localparam logic [3:0] FC_HVALUE  = 4'd9;

  // Grammar characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_P     = 8'h50;

  typedef enum logic [4:0] {
    PH_METHOD0, PH_METHOD, PH_URL, PH_SCHEME, PH_SL1, PH_SL2, PH_HOST0,
    PH_HOST, PH_PORT, PH_PATH, PH_QUERY, PH_SPVER, PH_VT1, PH_VT2, PH_VP,
    PH_VSL, PH_VD1, PH_VDOT, PH_VD2, PH_VAFTER, PH_VEND, PH_LF1, PH_LINE,
    PH_NAME, PH_HSP, PH_VALUE, PH_LF2, PH_LASTLF, PH_STOP
  } phase_t;

  typedef enum logic [1:0] {
    ST_PARSING = 2'd0,
    ST_DONE    = 2'd1,
    ST_ERROR   = 2'd2
  } status_t;

  // Parse control state carried from byte to byte
  typedef struct packed {
    phase_t     phase;
    logic       ver_given;
    status_t    status;
    logic [3:0] last_code;
  } ctrl_state_t;

  localparam ctrl_state_t CTRL_RESET = '{
    phase: PH_METHOD0, ver_given: 1'b0, status: ST_PARSING, last_code: FC_DELIM
  };

  // One result item
  typedef struct packed {
    logic [5:0] headers_seen;
    logic       version_defaulted;
    logic       head_error;
    logic       head_done;
    logic [4:0] header_number;
    logic       field_first;
    logic [3:0] field_code;
  } result_t;

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return is_upper(c) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

endpackage

### src/http_request_head_parser_core.sv
// A request byte accepted at a clock edge has its result registered at that edge and shown on m_tdata.
// Throughput: one byte per cycle while the output is not stalled; the output register lets a new byte enter while the
// previous result is taken in the same cycle.
// Reset (synchronous, rst high) returns the parse to the first method byte, clears the
// header count, version flag and status, and empties the output register.
// Depends on hrhp_pkg and hrhp_step.
`timescale 1ns / 1ps

module http_request_head_parser_core #(
  parameter int MAX_HEADERS = hrhp_pkg::MAX_HEADERS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_tuser,   // [0] start_flag
  output logic        m_tvalid,
  input  logic        m_tready,
  // [3:0] field_code, [4] field_first, [9:5] header_number, [10] head_done,
  // [11] head_error, [12] version_defaulted, [18:13] headers_seen, [23:19] zero
  output logic [23:0] m_tdata
);
  import hrhp_pkg::*;

  localparam int CNT_W = $clog2(MAX_HEADERS + 1);

  ctrl_state_t      ctrl;
  ctrl_state_t      ctrl_next;
  logic [CNT_W-1:0] hdr_total;
  logic [CNT_W-1:0] hdr_total_next;
  result_t          res_next;
  result_t          res;
  logic             accept;

  // Take a request whenever the output register is empty or draining
  assign s_tready = !m_tvalid || m_tready;
  assign accept = s_tvalid && s_tready;

  hrhp_step #(
    .MAX_HEADERS(MAX_HEADERS),
    .CNT_W      (CNT_W)
  ) u_step (
    .start_flag(s_tuser[0]),
    .data_byte (s_tdata),
    .cur       (ctrl),
    .hdr_cur   (hdr_total),
    .nxt       (ctrl_next),
    .hdr_nxt   (hdr_total_next),
    .res       (res_next)
  );

  // Advance parse state on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= CTRL_RESET;
      hdr_total <= '0;
    end else if (accept) begin
      ctrl <= ctrl_next;
      hdr_total <= hdr_total_next;
    end
  end

  // Hold the result until the downstream side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign m_tdata = {5'd0, res};

endmodule

### src/hrhp_step.sv
// Next-state and result logic for one request byte of the head parser.
// Depends on hrhp_pkg.
`timescale 1ns / 1ps

module hrhp_step #(
  parameter int MAX_HEADERS = hrhp_pkg::MAX_HEADERS_DEF,
  parameter int CNT_W       = $clog2(MAX_HEADERS + 1)
) (
  input  logic                  start_flag,
  input  logic [7:0]            data_byte,
  input  hrhp_pkg::ctrl_state_t cur,
  input  logic [CNT_W-1:0]      hdr_cur,
  output hrhp_pkg::ctrl_state_t nxt,
  output logic [CNT_W-1:0]      hdr_nxt,
  output hrhp_pkg::result_t     res
);
  import hrhp_pkg::*;

  localparam int EXT_W = (CNT_W > 6) ? CNT_W : 6;

  ctrl_state_t      base;
  logic [CNT_W-1:0] hbase;
  logic [EXT_W-1:0] hn_ext;
  logic [EXT_W-1:0] hs_ext;
  logic [3:0]       code;
  logic             first;
  phase_t           ph;
  logic             ok;
  logic             ver_set;
  logic             hinc;
  logic             done_set;
  logic [7:0]       c;

  assign c = data_byte;

  // Decode one byte against the current phase
  always_comb begin
    base = start_flag ? CTRL_RESET : cur;
    hbase = start_flag ? '0 : hdr_cur;
    nxt = base;
    hdr_nxt = hbase;
    code = FC_DELIM;
    first = 1'b0;
    ph = base.phase;
    ok = 1'b0;
    ver_set = 1'b0;
    hinc = 1'b0;
    done_set = 1'b0;
    if (base.status == ST_PARSING) begin
      case (base.phase)
        PH_METHOD0: begin
          if (is_upper(c) || c == CH_UNDER) begin code = FC_METHOD; ph = PH_METHOD; ok = 1'b1; end
        end
        PH_METHOD: begin
          if (is_upper(c) || c == CH_UNDER) begin code = FC_METHOD; ph = PH_METHOD; ok = 1'b1; end
          else if (c == CH_SP) begin ph = PH_URL; ok = 1'b1; end
        end
        PH_URL: begin
          if (is_alpha(c)) begin code = FC_SCHEME; ph = PH_SCHEME; ok = 1'b1; end
          else if (c == CH_SLASH) begin code = FC_PATH; ph = PH_PATH; ok = 1'b1; end
          else if (c == CH_CR) begin ph = PH_LF1; ok = 1'b1; end
          else if (c == CH_LF) begin ph = PH_LINE; ok = 1'b1; end
        end
        PH_SCHEME: begin
          if (is_alpha(c)) begin code = FC_SCHEME; ph = PH_SCHEME; ok = 1'b1; end
          else if (c == CH_COLON) begin ph = PH_SL1; ok = 1'b1; end
        end
        PH_SL1: begin
          if (c == CH_SLASH) begin ph = PH_SL2; ok = 1'b1; end
        end
        PH_SL2: begin
          if (c == CH_SLASH) begin ph = PH_HOST0; ok = 1'b1; end
        end
        PH_HOST0: begin
          if (is_alpha(c) || is_digit(c)) begin code = FC_HOST; ph = PH_HOST; ok = 1'b1; end
        end
        PH_HOST: begin
          if (is_alpha(c) || is_digit(c) || c == CH_DOT || c == CH_DASH) begin
            code = FC_HOST; ph = PH_HOST; ok = 1'b1;
          end else if (c == CH_COLON) begin ph = PH_PORT; ok = 1'b1; end
          else if (c == CH_SLASH) begin code = FC_PATH; ph = PH_PATH; ok = 1'b1; end
          else if (c == CH_SP) begin ph = PH_SPVER; ok = 1'b1; end
          else if (c == CH_CR) begin ph = PH_LF1; ok = 1'b1; end
          else if (c == CH_LF) begin ph = PH_LINE; ok = 1'b1; end
        end
        PH_PORT: begin
          if (is_digit(c)) begin code = FC_PORT; ph = PH_PORT; ok = 1'b1; end
          else if (c == CH_SP) begin ph = PH_SPVER; ok = 1'b1; end
          else if (c == CH_SLASH) begin code = FC_PATH; ph = PH_PATH; ok = 1'b1; end
        end
        PH_PATH, PH_QUERY: begin
          if (c == CH_NUL) ok = 1'b0;
          else if (c == CH_CR) begin ph = PH_LF1; ok = 1'b1; end
          else if (c == CH_LF) begin ph = PH_LINE; ok = 1'b1; end
          else if (c == CH_SP) begin ph = PH_SPVER; ok = 1'b1; end
          else if (c == CH_QUEST && base.phase == PH_PATH) begin ph = PH_QUERY; ok = 1'b1; end
          else begin
            code = (base.phase == PH_PATH) ? FC_PATH : FC_QUERY;
            ph = base.phase;
            ok = 1'b1;
          end
        end
        PH_SPVER: begin
          if (c == CH_H) begin code = FC_VERSION; ph = PH_VT1; ok = 1'b1; end
          else if (c == CH_CR) begin ph = PH_LF1; ok = 1'b1; end
          else if (c == CH_LF) begin ph = PH_LINE; ok = 1'b1; end
        end
        PH_VT1: begin
          if (c == CH_T) begin code = FC_VERSION; ph = PH_VT2; ok = 1'b1; end
        end
        PH_VT2: begin
          if (c == CH_T) begin code = FC_VERSION; ph = PH_VP; ok = 1'b1; end
        end
        PH_VP: begin
          if (c == CH_P) begin code = FC_VERSION; ph = PH_VSL; ok = 1'b1; end
        end
        PH_VSL: begin
          if (c == CH_SLASH) begin code = FC_VERSION; ph = PH_VD1; ok = 1'b1; end
        end
        PH_VD1: begin
          if (is_digit(c)) begin code = FC_VERSION; ph = PH_VDOT; ok = 1'b1; end
        end
        PH_VDOT: begin
          if (c == CH_DOT) begin code = FC_VERSION; ph = PH_VD2; ok = 1'b1; end
        end
        PH_VD2: begin
          if (is_digit(c)) begin
            code = FC_VERSION; ph = PH_VAFTER; ok = 1'b1; ver_set = 1'b1;
          end
        end
        PH_VAFTER: begin
          if (c == CH_SP) begin ph = PH_VEND; ok = 1'b1; end
          else if (c == CH_CR) begin ph = PH_LF1; ok = 1'b1; end
          else if (c == CH_LF) begin ph = PH_LINE; ok = 1'b1; end
        end
        PH_VEND: begin
          if (c == CH_CR) begin ph = PH_LF1; ok = 1'b1; end
          else if (c == CH_LF) begin ph = PH_LINE; ok = 1'b1; end
        end
        PH_LF1, PH_LF2: begin
          if (c == CH_LF) begin ph = PH_LINE; ok = 1'b1; end
        end
        PH_LINE: begin
          if (c == CH_CR) begin ph = PH_LASTLF; ok = 1'b1; end
          else if (c == CH_LF) begin ph = PH_STOP; ok = 1'b1; done_set = 1'b1; end
          else if (c == CH_NUL || hbase >= CNT_W'(MAX_HEADERS)) ok = 1'b0;
          else if (c == CH_COLON) begin ph = PH_HSP; ok = 1'b1; end
          else begin code = FC_HNAME; ph = PH_NAME; ok = 1'b1; end
        end
        PH_NAME: begin
          if (c == CH_COLON) begin ph = PH_HSP; ok = 1'b1; end
          else if (c != CH_NUL) begin code = FC_HNAME; ph = PH_NAME; ok = 1'b1; end
        end
        PH_HSP: begin
          if (c == CH_SP) begin ph = PH_VALUE; ok = 1'b1; end
        end
        PH_VALUE: begin
          if (c == CH_CR) begin ph = PH_LF2; ok = 1'b1; hinc = 1'b1; end
          else if (c == CH_LF) begin ph = PH_LINE; ok = 1'b1; hinc = 1'b1; end
          else if (c != CH_NUL) begin code = FC_HVALUE; ph = PH_VALUE; ok = 1'b1; end
        end
        PH_LASTLF: begin
          if (c == CH_LF) begin ph = PH_STOP; ok = 1'b1; done_set = 1'b1; end
        end
        default: begin
          ok = 1'b0;
        end
      endcase

      // Commit the phase, or stop on the first grammar break
      if (!ok) begin
        nxt.status = ST_ERROR;
        nxt.phase = PH_STOP;
        code = FC_DELIM;
      end else begin
        nxt.phase = ph;
        if (ver_set) nxt.ver_given = 1'b1;
        if (hinc) hdr_nxt = CNT_W'(hbase + 1'b1);
        if (done_set) nxt.status = ST_DONE;
      end
      first = (code != FC_DELIM) && (code != base.last_code);
      nxt.last_code = code;
    end
  end

  // Pack the result item
  assign hn_ext = EXT_W'(hbase);
  assign hs_ext = EXT_W'(hdr_nxt);

  always_comb begin
    res.field_code = code;
    res.field_first = first;
    res.header_number = hn_ext[4:0];
    res.head_done = (nxt.status == ST_DONE);
    res.head_error = (nxt.status == ST_ERROR);
    res.version_defaulted = (nxt.status == ST_DONE) && !nxt.ver_given;
    res.headers_seen = hs_ext[5:0];
  end

endmodule

### src/hrhp_checker.sv
// Port-level checks for the HTTP request head parser core, bound to the top level.
// Depends on http_request_head_parser_core.
`timescale 1ns / 1ps

module hrhp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // Done and error never show together
  a_done_err: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[10] && m_tdata[11]))
    else $error("head_done and head_error both set");

  // A field opening byte carries a nonzero code
  a_first_code: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[4]) |-> (m_tdata[3:0] != 4'd0))
    else $error("field_first on a delimiter");

  // Defaulted version only comes with done
  a_vdef: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[12]) |-> m_tdata[10])
    else $error("version_defaulted without head_done");

  // A stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result dropped or changed");

  // Hold off a request only while a result waits downstream
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && !s_tready) |-> (m_tvalid && !m_tready))
    else $error("request held off with the output free");

endmodule

bind http_request_head_parser_core hrhp_checker u_hrhp_checker (.*);
